// File: rtl/assert_macros.svh
// assertion macros for the gyro window integrator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/gwi_pkg.sv
// package of the gyro window integrator: widths, constants and shared types
package gwi_pkg;
	localparam int TIME_W = 48;
	localparam int SPAN_W = 32;
	localparam int RATE_W = 24;
	localparam int ACC_W = 48;
	localparam int SUM_W = 88;
	localparam int RING_DEPTH_DEF = 32;

	typedef struct packed {
		logic store;
		logic load_req;
		logic walk_init;
		logic rd_issue;
		logic step;
		logic load_out_super;
		logic load_out_done;
		logic clear_pending;
	} cmd_t;

	typedef struct packed {
		logic pending;
		logic newest_after;
		logic span_ok;
		logic last_k;
		logic brk;
		logic stop_ok;
		logic win_open;
	} sts_t;
endpackage

// File: rtl/gwi_ram.sv
// generic single port write, single read port ram with registered read
module gwi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/gwi_datapath.sv
// datapath: sample ring, pending request, overlap weighting and accumulators
module gwi_datapath #(
	parameter int RING_DEPTH = gwi_pkg::RING_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gwi_pkg::cmd_t               cmd,
	output gwi_pkg::sts_t               sts,
	input  logic [gwi_pkg::TIME_W-1:0]  in_time,
	input  logic [gwi_pkg::SPAN_W-1:0]  in_span,
	input  logic signed [gwi_pkg::RATE_W-1:0] in_rx,
	input  logic signed [gwi_pkg::RATE_W-1:0] in_ry,
	input  logic signed [gwi_pkg::RATE_W-1:0] in_rz,
	output logic [gwi_pkg::TIME_W-1:0]  out_time_q,
	output logic signed [gwi_pkg::ACC_W-1:0] out_x_q,
	output logic signed [gwi_pkg::ACC_W-1:0] out_y_q,
	output logic signed [gwi_pkg::ACC_W-1:0] out_z_q,
	output logic                        out_valid_field_q
);
	localparam int AW = $clog2(RING_DEPTH);
	localparam int TW = gwi_pkg::TIME_W;
	localparam int RW = gwi_pkg::RATE_W;
	localparam int SW = gwi_pkg::SUM_W;
	localparam int MW = RW + gwi_pkg::SPAN_W + 1;
	localparam int RAM_W = TW + 3 * RW;
	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

	logic [AW-1:0] wslot_q, rptr_q, k_q;
	logic [RING_DEPTH-1:0] vld_q;
	logic pend_q;
	logic [TW-1:0] end_q, start_q, last_q, newest_q;
	logic [gwi_pkg::SPAN_W-1:0] span_q;
	logic win_open_q, stop_ok_q;
	logic signed [SW-1:0] acc_x_q, acc_y_q, acc_z_q;
	logic [RAM_W-1:0] rd_raw;
	logic rd_vld_q;
	logic [TW-1:0] cur;
	logic signed [RW-1:0] cx, cy, cz;
	logic s_ok, st_ok, brk, use_term;
	logic [TW-1:0] lo, hi;
	logic [gwi_pkg::SPAN_W-1:0] w;
	logic signed [MW-1:0] px, py, pz;
	logic [AW-1:0] ridx;

	gwi_ram #(.WIDTH(RAM_W), .DEPTH(RING_DEPTH)) u_ring (
		.clk(clk), .we(cmd.store), .waddr(wslot_q),
		.wdata({in_time, in_rx, in_ry, in_rz}), .raddr(ridx), .rdata(rd_raw)
	);

	assign ridx = cmd.walk_init ? wslot_q : rptr_q;
	assign {cur, cx, cy, cz} = rd_vld_q ? rd_raw : '0;

	always_comb begin
		s_ok = win_open_q;
		st_ok = stop_ok_q;
		brk = 1'b0;
		if (!win_open_q && cur > start_q) begin
			if (last_q > start_q) begin
				brk = 1'b1;
			end else begin
				s_ok = 1'b1;
				st_ok = cur > end_q;
			end
		end else if (!stop_ok_q && cur > end_q) begin
			st_ok = 1'b1;
		end
		use_term = s_ok && !brk;
		lo = last_q > start_q ? last_q : start_q;
		hi = cur < end_q ? cur : end_q;
		// the overlap never exceeds the span
		w = hi > lo ? gwi_pkg::SPAN_W'(hi - lo) : '0;
		px = cx * $signed({1'b0, w});
		py = cy * $signed({1'b0, w});
		pz = cz * $signed({1'b0, w});
	end

	function automatic logic signed [gwi_pkg::ACC_W-1:0] sat(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] hi_l, lo_l;
		hi_l = SW'({1'b0, {(gwi_pkg::ACC_W-1){1'b1}}});
		lo_l = -hi_l - SW'(1);
		if (s > hi_l) sat = hi_l[gwi_pkg::ACC_W-1:0];
		else if (s < lo_l) sat = lo_l[gwi_pkg::ACC_W-1:0];
		else sat = s[gwi_pkg::ACC_W-1:0];
	endfunction

	assign sts.pending = pend_q;
	assign sts.newest_after = newest_q > end_q;
	assign sts.span_ok = {16'b0, span_q} <= end_q;
	assign sts.last_k = k_q == LAST_SLOT;
	assign sts.brk = brk;
	assign sts.stop_ok = st_ok;
	assign sts.win_open = s_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q <= '0;
			vld_q <= '0;
			pend_q <= 1'b0;
			end_q <= '0;
			span_q <= '0;
			newest_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				vld_q[wslot_q] <= 1'b1;
				newest_q <= in_time;
				wslot_q <= (wslot_q == LAST_SLOT) ? '0 : wslot_q + AW'(1);
			end
			if (cmd.load_req) begin
				pend_q <= 1'b1;
				end_q <= in_time;
				span_q <= in_span;
			end
			if (cmd.clear_pending) begin
				pend_q <= 1'b0;
			end
			if (cmd.walk_init || cmd.rd_issue) begin
				rd_vld_q <= vld_q[ridx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			start_q <= end_q - {16'b0, span_q};
			rptr_q <= (wslot_q == LAST_SLOT) ? '0 : wslot_q + AW'(1);
			k_q <= AW'(1);
			win_open_q <= 1'b0;
			stop_ok_q <= 1'b0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
			last_q <= '0;
		end
		if (cmd.rd_issue) begin
			rptr_q <= (rptr_q == LAST_SLOT) ? '0 : rptr_q + AW'(1);
		end
		if (cmd.step) begin
			last_q <= cur;
			win_open_q <= s_ok;
			stop_ok_q <= st_ok;
			k_q <= k_q + AW'(1);
			if (use_term) begin
				acc_x_q <= acc_x_q + SW'(px);
				acc_y_q <= acc_y_q + SW'(py);
				acc_z_q <= acc_z_q + SW'(pz);
			end
		end
		if (cmd.rd_issue && !cmd.step) begin
			last_q <= cur;
		end
		if (cmd.load_out_super) begin
			out_time_q <= end_q;
			out_x_q <= '0;
			out_y_q <= '0;
			out_z_q <= '0;
			out_valid_field_q <= 1'b0;
		end
		if (cmd.load_out_done) begin
			out_time_q <= end_q;
			out_x_q <= sat(acc_x_q);
			out_y_q <= sat(acc_y_q);
			out_z_q <= sat(acc_z_q);
			out_valid_field_q <= 1'b1;
		end
	end
endmodule

// File: rtl/gwi_ctrl.sv
// controller state machine sequencing accept, supersede, walk and result
`include "assert_macros.svh"
module gwi_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_type,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          out_last_q,
	output gwi_pkg::cmd_t cmd,
	input  gwi_pkg::sts_t sts
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_CHECK, ST_OLDEST, ST_WALK, ST_DONE, ST_OUT
	} state_t;

	state_t state_q;
	logic out_vld_q, sup_q;
	logic accept, is_req, raise, raise_last;

	assign out_valid = out_vld_q;
	assign in_ready = state_q == ST_IDLE && !out_vld_q;
	assign accept = in_valid && in_ready;
	assign is_req = in_type;

	always_comb begin
		cmd = '0;
		raise = 1'b0;
		raise_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.store = accept && !is_req;
				cmd.load_req = accept && is_req;
				// old request goes to the output registers, shown once the walk is known
				cmd.load_out_super = accept && is_req && sts.pending;
			end
			ST_CHECK: begin
				cmd.walk_init = sts.pending && sts.newest_after && sts.span_ok;
				raise = !cmd.walk_init && sup_q;
				raise_last = 1'b1;
			end
			ST_OLDEST: cmd.rd_issue = 1'b1;
			ST_WALK: begin
				cmd.step = 1'b1;
				cmd.rd_issue = 1'b1;
				cmd.clear_pending = sts.stop_ok && sts.win_open && !sts.brk;
				raise = !cmd.clear_pending && (sts.brk || sts.last_k) && sup_q;
				raise_last = 1'b1;
			end
			ST_DONE: begin
				cmd.load_out_done = !sup_q;
				raise = 1'b1;
				raise_last = !sup_q;
			end
			ST_OUT: begin
				cmd.load_out_done = out_ready;
				raise = out_ready;
				raise_last = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_vld_q <= 1'b0;
			out_last_q <= 1'b0;
			sup_q <= 1'b0;
		end else begin
			out_vld_q <= raise || (out_vld_q && !out_ready);
			if (raise) begin
				out_last_q <= raise_last;
			end
			if (state_q == ST_IDLE) begin
				if (accept) begin
					sup_q <= is_req && sts.pending;
				end
			end else if (raise) begin
				sup_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= cmd.walk_init ? ST_OLDEST : ST_IDLE;
				end
				ST_OLDEST: state_q <= ST_WALK;
				ST_WALK: begin
					if (cmd.clear_pending) begin
						state_q <= ST_DONE;
					end else if (sts.brk || sts.last_k) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					state_q <= sup_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_no_accept_busy, state_q != ST_IDLE, !in_ready, "input taken while busy")
	`ASSERT_NEXT(a_raise_shows, raise, out_valid, "result not presented")
	`ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid && $stable(out_last_q), "result dropped while stalled")
	`ASSERT_IMPL(a_walk_out_idle, state_q == ST_WALK, !out_valid, "walk with result waiting")
endmodule

// File: rtl/gyro_window_integrator.sv
// top level of the gyro window integrator
// Channels: input items on in_valid/in_ready with req_type, item_time,
// window_span and rate_x/y/z; results on out_valid/out_ready with
// flow_end_time, integral_x/y/z, integrals_valid and last_of_run.
// A gyro sample is written into a ring of RING_DEPTH entries; a flow request
// is held pending. A request arriving over a pending one first gives a
// result with integrals_valid low. After each item, if the newest sample is
// later than the pending end time and the window span does not exceed it, the
// ring is walked oldest to newest, one entry per cycle through the registered
// ring memory read port. An item with no walk passes through the accept and
// check states; a walk adds a state that takes in the oldest entry, then steps
// one entry at a time towards the newest.
// A superseded request and a completed one give two results; the second is
// loaded as the first is taken.
// At most two results follow one item; last_of_run marks the final one.
// Reset clears the ring valid bits, write slot and pending request; entries
// never written read as zero.
// When the receiver stalls the result holds in the output register and the
// block takes no new item until it is taken.
module gyro_window_integrator #(
	parameter int RING_DEPTH = gwi_pkg::RING_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic req_type,
	input  logic [gwi_pkg::TIME_W-1:0] item_time,
	input  logic [gwi_pkg::SPAN_W-1:0] window_span,
	input  logic signed [gwi_pkg::RATE_W-1:0] rate_x,
	input  logic signed [gwi_pkg::RATE_W-1:0] rate_y,
	input  logic signed [gwi_pkg::RATE_W-1:0] rate_z,
	output logic out_valid,
	input  logic out_ready,
	output logic [gwi_pkg::TIME_W-1:0] flow_end_time,
	output logic signed [gwi_pkg::ACC_W-1:0] integral_x,
	output logic signed [gwi_pkg::ACC_W-1:0] integral_y,
	output logic signed [gwi_pkg::ACC_W-1:0] integral_z,
	output logic integrals_valid,
	output logic last_of_run
);
	gwi_pkg::cmd_t cmd;
	gwi_pkg::sts_t sts;
	logic last_q;

	gwi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_type(req_type), .out_valid(out_valid), .out_ready(out_ready),
		.out_last_q(last_q), .cmd(cmd), .sts(sts)
	);

	gwi_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_time(item_time), .in_span(window_span),
		.in_rx(rate_x), .in_ry(rate_y), .in_rz(rate_z),
		.out_time_q(flow_end_time), .out_x_q(integral_x), .out_y_q(integral_y),
		.out_z_q(integral_z), .out_valid_field_q(integrals_valid)
	);

	assign last_of_run = last_q;
endmodule

// File: tb/sv/gyro_window_integrator_tb.sv
// testbench of the gyro window integrator: random and directed items checked against a flow predictor
module gyro_window_integrator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TIME_W = gwi_pkg::TIME_W;
	localparam int SPAN_W = gwi_pkg::SPAN_W;
	localparam int RATE_W = gwi_pkg::RATE_W;
	localparam int ACC_W = gwi_pkg::ACC_W;
	localparam int DEPTH = gwi_pkg::RING_DEPTH_DEF;
	localparam int WATCH_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic req;
		logic [TIME_W-1:0] t;
		logic [SPAN_W-1:0] span;
		logic signed [RATE_W-1:0] rx, ry, rz;
	} item_t;

	typedef struct {
		logic [TIME_W-1:0] t;
		logic signed [ACC_W-1:0] ix, iy, iz;
		logic ok, last;
	} flow_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, req_type = 0;
	logic [TIME_W-1:0] item_time = 0;
	logic [SPAN_W-1:0] window_span = 0;
	logic signed [RATE_W-1:0] rate_x = 0, rate_y = 0, rate_z = 0;
	logic out_valid, out_ready = 0;
	logic [TIME_W-1:0] flow_end_time;
	logic signed [ACC_W-1:0] integral_x, integral_y, integral_z;
	logic integrals_valid, last_of_run;

	gyro_window_integrator uut (.*);

	always #10 clk = ~clk;

	item_t pending_items[$];
	flow_t expected_flows[$];
	int errors = 0;
	bit quiet_in = 0, quiet_out = 0;
	bit hold_go = 0, stalled = 0;
	int idle_cycles = 0;

	// predictor state
	logic [TIME_W-1:0] p_time[DEPTH] = '{default: '0};
	logic signed [RATE_W-1:0] p_rx[DEPTH] = '{default: '0};
	logic signed [RATE_W-1:0] p_ry[DEPTH] = '{default: '0};
	logic signed [RATE_W-1:0] p_rz[DEPTH] = '{default: '0};
	int p_slot = 0;
	bit p_pend = 0;
	logic [TIME_W-1:0] p_end = 0;
	logic [SPAN_W-1:0] p_span = 0;

	function automatic logic signed [ACC_W-1:0] clamp48(longint signed s);
		if (s > 64'sh7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
		if (s < -64'sh800000000000) return 48'sh800000000000;
		return s[ACC_W-1:0];
	endfunction

	function automatic bit window_sum(output longint signed ax, ay, az);
		logic [TIME_W-1:0] start, last, cur, lo, hi;
		bit s_ok, e_ok;
		int idx;
		longint signed w;
		ax = 0; ay = 0; az = 0; s_ok = 0; e_ok = 0;
		if (p_span > p_end) return 0;
		start = p_end - p_span;
		last = p_time[p_slot];
		for (int k = 1; k < DEPTH; k++) begin
			idx = (p_slot + k) % DEPTH;
			cur = p_time[idx];
			if (!s_ok && cur > start) begin
				if (last > start) break;
				s_ok = 1;
				if (cur > p_end) e_ok = 1;
			end else if (!e_ok && cur > p_end) e_ok = 1;
			if (s_ok) begin
				lo = last > start ? last : start;
				hi = cur < p_end ? cur : p_end;
				w = hi > lo ? longint'(hi - lo) : 0;
				ax += longint'(p_rx[idx]) * w;
				ay += longint'(p_ry[idx]) * w;
				az += longint'(p_rz[idx]) * w;
			end
			last = cur;
			if (e_ok) break;
		end
		return s_ok && e_ok;
	endfunction

	function automatic void predict_flow(item_t it);
		flow_t f[$];
		flow_t r;
		longint signed ax, ay, az;
		if (!it.req) begin
			p_time[p_slot] = it.t;
			p_rx[p_slot] = it.rx; p_ry[p_slot] = it.ry; p_rz[p_slot] = it.rz;
			p_slot = (p_slot + 1) % DEPTH;
		end else begin
			if (p_pend) begin
				r = '{p_end, '0, '0, '0, 1'b0, 1'b0};
				f.push_back(r);
			end
			p_pend = 1; p_end = it.t; p_span = it.span;
		end
		if (p_pend && p_time[(p_slot + DEPTH - 1) % DEPTH] > p_end)
			if (window_sum(ax, ay, az)) begin
				r = '{p_end, clamp48(ax), clamp48(ay), clamp48(az), 1'b1, 1'b0};
				f.push_back(r);
				p_pend = 0;
			end
		if (f.size() > 0) f[f.size()-1].last = 1;
		foreach (f[i]) expected_flows.push_back(f[i]);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_flow('{req_type, item_time, window_span, rate_x, rate_y, rate_z});
				pending_items.pop_front();
			end
			if (!(in_valid && !in_ready)) begin
				if (pending_items.size() > 0 && (quiet_in || $urandom_range(99) >= 25)) begin
					in_valid <= 1;
					req_type <= pending_items[0].req;
					item_time <= pending_items[0].t;
					window_span <= pending_items[0].span;
					rate_x <= pending_items[0].rx;
					rate_y <= pending_items[0].ry;
					rate_z <= pending_items[0].rz;
				end else in_valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		flow_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_flows.size() == 0) begin
					$display("%0t unexpected result end=%h", $time, flow_end_time);
					errors++;
				end else begin
					e = expected_flows.pop_front();
					if ({flow_end_time, integral_x, integral_y, integral_z,
						integrals_valid, last_of_run} !==
						{e.t, e.ix, e.iy, e.iz, e.ok, e.last}) begin
						$display("%0t mismatch exp end=%h x=%h y=%h z=%h v=%b l=%b",
							$time, e.t, e.ix, e.iy, e.iz, e.ok, e.last);
						$display("%0t          act end=%h x=%h y=%h z=%h v=%b l=%b",
							$time, flow_end_time, integral_x, integral_y, integral_z,
							integrals_valid, last_of_run);
						errors++;
					end
				end
			end
			if (stalled) out_ready <= 0;
			else out_ready <= quiet_out || $urandom_range(99) >= 25;
		end
	end

	// receiver hold-off
	initial begin
		wait (hold_go);
		stalled <= 1;
		repeat (HOLD_CYCLES) @(posedge clk);
		stalled <= 0;
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("FAIL gyro_window_integrator");
				$finish;
			end
		end
	end

	logic [TIME_W-1:0] now_t = 0;

	function automatic logic signed [RATE_W-1:0] rnd_rate();
		case ($urandom_range(5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			default: return RATE_W'($urandom);
		endcase
	endfunction

	task automatic add_sample(logic [TIME_W-1:0] t);
		pending_items.push_back('{1'b0, t, $urandom, rnd_rate(), rnd_rate(), rnd_rate()});
	endtask

	task automatic add_flow(logic [TIME_W-1:0] t, logic [SPAN_W-1:0] s);
		pending_items.push_back('{1'b1, t, s, RATE_W'($urandom), RATE_W'($urandom),
			RATE_W'($urandom)});
	endtask

	initial begin
		logic [TIME_W-1:0] t;
		int n;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		// directed: before history, supersede, extremes, non-monotonic, huge span
		add_flow(100, 50);
		add_flow(200, 500);
		add_sample(150); add_sample(210);
		add_flow(48'hFFFFFFFFFFFF, 32'hFFFFFFFF);
		add_flow(300, 0);
		pending_items.push_back('{1'b0, 48'd400, 32'hFFFFFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF});
		add_flow(390, 60);
		pending_items.push_back('{1'b0, 48'd380, '0, 24'sh123456, 24'sh800000, '0});
		pending_items.push_back('{1'b0, 48'd1000, '0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF});
		add_flow(395, 10);
		add_flow(999, 620);
		pending_items.push_back('{1'b0, 48'h7FFFFFFF0000, '0, 24'sh7FFFFF, 24'sh800000,
			24'sh7FFFFF});
		add_flow(48'h7FFFFFFE0000, 32'hFFFFFFFF);
		add_sample(48'hFFFFFFFFFFFF);
		add_flow(48'hFFFFFFFFFFFE, 32'hFFFFFFFF);
		add_sample(48'hFFFFFFFFFFFF);
		add_sample(5000);
		now_t = 5000;
		t = 0;
		for (int i = 0; i < 1430; i++) begin
			n = $urandom_range(99);
			if (n < 70) begin
				now_t += $urandom_range(400, 1);
				if ($urandom_range(30) == 0) now_t -= $urandom_range(800);
				add_sample(now_t);
			end else if (n < 95) begin
				t = now_t - $urandom_range(3000);
				add_flow(t, $urandom_range(20) == 0 ? $urandom : $urandom_range(6000));
			end else if (n < 98) add_flow($urandom, $urandom);
			else begin
				add_sample(TIME_W'({$urandom, $urandom}));
				add_sample(now_t);
			end
			if (i == 300) begin
				wait (pending_items.size() == 0);
				@(posedge clk);
				hold_go = 1;
			end
			if (i == 600) begin
				wait (pending_items.size() == 0);
				quiet_in = 1; quiet_out = 1;
			end
			if (i == 800) begin
				wait (pending_items.size() == 0);
				quiet_in = 0; quiet_out = 0;
			end
		end
		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_flows.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_flows.size() == 0)
			$display("PASS gyro_window_integrator");
		else
			$display("FAIL gyro_window_integrator");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/gwi_pkg.sv
rtl/gwi_ram.sv
rtl/gwi_datapath.sv
rtl/gwi_ctrl.sv
rtl/gyro_window_integrator.sv
tb/sv/gyro_window_integrator_tb.sv
